@@ rtl/core/usp_pkg.sv @@
// Shared types, constants and helper functions of the URL split parser.
package usp_pkg;

  localparam int unsigned USP_MAX_LEN     = 256;
  localparam int unsigned USP_QUEUE_DEPTH = 2;

  localparam logic [31:0] FNV_BASIS  = 32'h811c9dc5;
  localparam logic [31:0] HASH_HTTP  = 32'hc96448a5;
  localparam logic [31:0] HASH_HTTPS = 32'hdedea8e2;

  localparam logic [15:0] PORT_HTTP  = 16'd80;
  localparam logic [15:0] PORT_HTTPS = 16'd443;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NO_SCHEME,
    ST_NO_HOST_END,
    ST_OPEN_BRACKET
  } usp_status_e;

  typedef enum logic [1:0] {
    KIND_OTHER,
    KIND_HTTP,
    KIND_HTTPS
  } usp_kind_e;

  typedef enum logic [3:0] {
    CLS_OTHER,
    CLS_COLON,
    CLS_SLASH,
    CLS_LBRACK,
    CLS_RBRACK,
    CLS_SPACE,
    CLS_PLUS,
    CLS_MINUS,
    CLS_DIGIT
  } usp_cls_e;

  // One queued byte: raw value, its class, whether it is parsed and the end mark.
  typedef struct packed {
    logic [7:0] data;
    usp_cls_e   cls;
    logic       take;
    logic       last;
  } usp_entry_t;

  function automatic usp_cls_e usp_classify(input logic [7:0] b);
    usp_cls_e c;
    c = CLS_OTHER;
    if (b == CH_COLON) c = CLS_COLON;
    else if (b == CH_SLASH) c = CLS_SLASH;
    else if (b == CH_LBRACK) c = CLS_LBRACK;
    else if (b == CH_RBRACK) c = CLS_RBRACK;
    else if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) c = CLS_SPACE;
    else if (b == CH_PLUS) c = CLS_PLUS;
    else if (b == CH_MINUS) c = CLS_MINUS;
    else if (b >= CH_ZERO && b <= CH_NINE) c = CLS_DIGIT;
    return c;
  endfunction

  // FNV-1a step; the prime 0x01000193 is applied as a sum of shifts.
  function automatic logic [31:0] usp_fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
  endfunction

endpackage

@@ rtl/core/usp_if.sv @@
// Request channel interfaces of the URL split parser.
interface usp_in_if import usp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] url_byte;
  logic       last_byte;

  modport source (output valid, output url_byte, output last_byte, input ready);
  modport sink   (input valid, input url_byte, input last_byte, output ready);
endinterface

interface usp_out_if import usp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  scheme_kind;
  logic [7:0]  host_start;
  logic [7:0]  host_length;
  logic [15:0] port;
  logic        port_known;
  logic        path_present;
  logic [7:0]  path_start;

  modport source (output valid, output status, output scheme_kind, output host_start,
                  output host_length, output port, output port_known,
                  output path_present, output path_start, input ready);
  modport sink   (input valid, input status, input scheme_kind, input host_start,
                  input host_length, input port, input port_known,
                  input path_present, input path_start, output ready);
endinterface

@@ rtl/core/url_split_parser_unit.sv @@
// Top level of the URL split parser: front end, byte queue and parser back end.
//
// The block takes a URL one byte per request on url_i, with last_byte set on
// the final byte, and returns one result request on result_o for each URL:
// status, scheme kind (http or https by FNV-1a 32 hash of the text before the
// first "://"), host start and length, port (explicit decimal port, else 80 or
// 443 by scheme), and the path start just after the path slash. A zero byte ends
// the string and later bytes up to last_byte are dropped; bytes at positions of
// MAX_LEN and above are dropped too. Index fields are the low 8 bits of the
// byte position. Throughput is one byte per clock cycle, set by the parser
// back end that applies one byte, including its hash multiply, per cycle; a
// last byte waits while the result register still holds an untaken result.
// With the byte queue empty, the last byte is written into the byte queue and
// the back end loads the result register as it takes it. That register holds
// the request until taken while the next URL keeps streaming in.
module url_split_parser_unit import usp_pkg::*; #(
  parameter int unsigned MAX_LEN     = USP_MAX_LEN,
  parameter int unsigned QUEUE_DEPTH = USP_QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  usp_in_if.sink    url_i,
  usp_out_if.source result_o
);

  // Front end to queue.
  logic       push_valid, push_ready;
  usp_entry_t push_entry;

  // Queue to back end.
  logic       pop_valid, pop_ready;
  usp_entry_t pop_entry;

  // Classify bytes and mark which ones are parsed.
  usp_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .url_i        (url_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  // Decouple the byte stream from result back pressure.
  usp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // Parse and hold the result.
  usp_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .result_o    (result_o)
  );

endmodule

@@ rtl/core/usp_front.sv @@
// Front end: accepts bytes, classifies them and tracks string end and capacity.
module usp_front import usp_pkg::*; #(
  parameter int unsigned MAX_LEN = USP_MAX_LEN
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  usp_in_if.sink       url_i,
  output logic         push_valid_o,
  input  logic         push_ready_i,
  output usp_entry_t   push_entry_o
);

  localparam int unsigned PW = $clog2(MAX_LEN + 1);

  logic          ended_q, ended_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          accept;
  logic          take;

  assign url_i.ready  = push_ready_i;
  assign push_valid_o = url_i.valid;
  assign accept       = url_i.valid && push_ready_i;

  // Parse a byte only before the terminating zero and below capacity.
  assign take = !ended_q && (url_i.url_byte != CH_NUL) && (pos_q < PW'(MAX_LEN));

  assign push_entry_o.data = url_i.url_byte;
  assign push_entry_o.cls  = usp_classify(url_i.url_byte);
  assign push_entry_o.take = take;
  assign push_entry_o.last = url_i.last_byte;

  always_comb begin
    ended_d = ended_q;
    pos_d   = pos_q;
    if (accept) begin
      if (url_i.last_byte) begin
        ended_d = 1'b0;
        pos_d   = '0;
      end else if (!ended_q && url_i.url_byte == CH_NUL) begin
        ended_d = 1'b1;
      end else if (take) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ended_q <= 1'b0;
      pos_q   <= '0;
    end else begin
      ended_q <= ended_d;
      pos_q   <= pos_d;
    end
  end

endmodule

@@ rtl/core/usp_queue.sv @@
// Small FIFO between the front end and the parser back end.
module usp_queue import usp_pkg::*; #(
  parameter int unsigned DEPTH = USP_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  usp_entry_t push_entry_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output usp_entry_t pop_entry_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  usp_entry_t    slots_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [AW:0]   count_q;
  logic          push, pop;

  assign push_ready_o = (count_q < (AW+1)'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = slots_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // Wrap the pointers at the last slot so that any depth works.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop) rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push && !pop) count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

endmodule

@@ rtl/core/usp_back.sv @@
// Back end: scheme hash, host/port/path parser and the result register.
module usp_back import usp_pkg::*; #(
  parameter int unsigned MAX_LEN = USP_MAX_LEN
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  usp_entry_t pop_entry_i,
  usp_out_if.source  result_o
);

  localparam int unsigned PW = $clog2(MAX_LEN + 1);

  localparam logic [2:0] PH_SCHEME        = 3'd0;
  localparam logic [2:0] PH_HOST_FIRST    = 3'd1;
  localparam logic [2:0] PH_PLAIN         = 3'd2;
  localparam logic [2:0] PH_BRACKET       = 3'd3;
  localparam logic [2:0] PH_AFTER_BRACKET = 3'd4;
  localparam logic [2:0] PH_PORT          = 3'd5;
  localparam logic [2:0] PH_SEEK_SLASH    = 3'd6;
  localparam logic [2:0] PH_DONE          = 3'd7;

  localparam logic [1:0] AT_SPACE  = 2'd0;
  localparam logic [1:0] AT_DIGITS = 2'd1;
  localparam logic [1:0] AT_STOP   = 2'd2;

  logic [2:0]    phase_q, phase_d;
  logic [31:0]   hash_q, hash_d;
  logic [15:0]   recent_q, recent_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] host_begin_q, host_begin_d;
  logic [PW-1:0] host_end_q, host_end_d;
  logic [15:0]   acc_q, acc_d;
  logic [PW-1:0] path_begin_q, path_begin_d;
  logic          path_found_q, path_found_d;
  logic          colon_q, colon_d;
  logic          slash_q, slash_d;
  logic [PW-1:0] first_slash_q, first_slash_d;
  logic [1:0]    atoi_q, atoi_d;
  logic          neg_q, neg_d;

  logic          do_plain, do_enter, do_path, do_port;
  logic [15:0]   acc_times10;
  logic          pop, out_free;

  usp_status_e   res_status;
  usp_kind_e     res_kind;
  logic [PW-1:0] res_host_end, res_path_begin;
  logic          res_path_found;
  logic [15:0]   res_port;
  logic          res_known;

  logic          out_valid_q;
  logic [1:0]    status_q, kind_q;
  logic [7:0]    host_start_q, host_length_q, path_start_q;
  logic [15:0]   port_q;
  logic          known_q, path_present_q;

  assign out_free    = !out_valid_q || result_o.ready;
  assign pop_ready_o = !pop_entry_i.last || out_free;
  assign pop         = pop_valid_i && pop_ready_o;

  assign acc_times10 = (acc_q << 3) + (acc_q << 1) + {12'd0, pop_entry_i.data[3:0]};

  // Apply one byte to the parser state.
  always_comb begin
    phase_d       = phase_q;
    hash_d        = hash_q;
    recent_d      = recent_q;
    pos_d         = pos_q;
    host_begin_d  = host_begin_q;
    host_end_d    = host_end_q;
    acc_d         = acc_q;
    path_begin_d  = path_begin_q;
    path_found_d  = path_found_q;
    colon_d       = colon_q;
    slash_d       = slash_q;
    first_slash_d = first_slash_q;
    atoi_d        = atoi_q;
    neg_d         = neg_q;
    do_plain      = 1'b0;
    do_enter      = 1'b0;
    do_path       = 1'b0;
    do_port       = 1'b0;

    if (pop_entry_i.take) begin
      pos_d = pos_q + 1'b1;
      case (phase_q)
        PH_SCHEME: begin
          if (pos_q >= PW'(2) && recent_q[15:8] == CH_COLON && recent_q[7:0] == CH_SLASH &&
              pop_entry_i.data == CH_SLASH) begin
            phase_d = PH_HOST_FIRST;
          end else begin
            if (pos_q >= PW'(2)) hash_d = usp_fnv_step(hash_q, recent_q[15:8]);
            recent_d = {recent_q[7:0], pop_entry_i.data};
          end
        end
        PH_HOST_FIRST: begin
          if (pop_entry_i.cls == CLS_LBRACK) begin
            host_begin_d = pos_q + 1'b1;
            phase_d      = PH_BRACKET;
          end else begin
            host_begin_d = pos_q;
            phase_d      = PH_PLAIN;
            do_plain     = 1'b1;
          end
        end
        PH_PLAIN: do_plain = 1'b1;
        PH_BRACKET: begin
          if (pop_entry_i.cls == CLS_RBRACK) begin
            host_end_d = pos_q;
            phase_d    = PH_AFTER_BRACKET;
          end
        end
        PH_AFTER_BRACKET: begin
          if (pop_entry_i.cls == CLS_COLON) do_enter = 1'b1;
          else if (pop_entry_i.cls == CLS_SLASH) do_path = 1'b1;
          else phase_d = PH_SEEK_SLASH;
        end
        PH_PORT: begin
          if (pop_entry_i.cls == CLS_SLASH) do_path = 1'b1;
          else do_port = 1'b1;
        end
        PH_SEEK_SLASH: begin
          if (pop_entry_i.cls == CLS_SLASH) do_path = 1'b1;
        end
        default: ;
      endcase
    end

    if (do_plain) begin
      if (pop_entry_i.cls == CLS_COLON) begin
        host_end_d = pos_q;
        do_enter   = 1'b1;
      end else if (pop_entry_i.cls == CLS_SLASH && !slash_q) begin
        slash_d       = 1'b1;
        first_slash_d = pos_q;
      end
    end

    if (do_enter) begin
      colon_d = 1'b1;
      atoi_d  = AT_SPACE;
      neg_d   = 1'b0;
      acc_d   = '0;
      phase_d = PH_PORT;
    end

    if (do_path) begin
      path_found_d = 1'b1;
      path_begin_d = pos_q + 1'b1;
      phase_d      = PH_DONE;
    end

    // Port text: skip white space, take one sign, then digits.
    if (do_port) begin
      case (atoi_q)
        AT_SPACE: begin
          if (pop_entry_i.cls == CLS_SPACE) begin
            atoi_d = AT_SPACE;
          end else if (pop_entry_i.cls == CLS_PLUS || pop_entry_i.cls == CLS_MINUS) begin
            neg_d  = (pop_entry_i.cls == CLS_MINUS);
            atoi_d = AT_DIGITS;
          end else if (pop_entry_i.cls == CLS_DIGIT) begin
            acc_d  = acc_times10;
            atoi_d = AT_DIGITS;
          end else begin
            atoi_d = AT_STOP;
          end
        end
        AT_DIGITS: begin
          if (pop_entry_i.cls == CLS_DIGIT) acc_d = acc_times10;
          else atoi_d = AT_STOP;
        end
        default: ;
      endcase
    end
  end

  // Build the result from the state after the last byte.
  always_comb begin
    res_status     = ST_OK;
    res_host_end   = host_end_d;
    res_path_found = path_found_d;
    res_path_begin = path_begin_d;
    case (phase_d)
      PH_SCHEME:     res_status = ST_NO_SCHEME;
      PH_HOST_FIRST: res_status = ST_NO_HOST_END;
      PH_BRACKET:    res_status = ST_OPEN_BRACKET;
      PH_PLAIN: begin
        if (slash_d) begin
          res_host_end   = first_slash_d;
          res_path_found = 1'b1;
          res_path_begin = first_slash_d + 1'b1;
        end else begin
          res_status = ST_NO_HOST_END;
        end
      end
      default: ;
    endcase

    if (hash_d == HASH_HTTP) res_kind = KIND_HTTP;
    else if (hash_d == HASH_HTTPS) res_kind = KIND_HTTPS;
    else res_kind = KIND_OTHER;

    res_port  = '0;
    res_known = 1'b0;
    if (colon_d) begin
      res_port  = neg_d ? (16'd0 - acc_d) : acc_d;
      res_known = 1'b1;
    end else if (res_kind == KIND_HTTP) begin
      res_port  = PORT_HTTP;
      res_known = 1'b1;
    end else if (res_kind == KIND_HTTPS) begin
      res_port  = PORT_HTTPS;
      res_known = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_SCHEME;
      hash_q        <= FNV_BASIS;
      recent_q      <= '0;
      pos_q         <= '0;
      host_begin_q  <= '0;
      host_end_q    <= '0;
      acc_q         <= '0;
      path_begin_q  <= '0;
      path_found_q  <= 1'b0;
      colon_q       <= 1'b0;
      slash_q       <= 1'b0;
      first_slash_q <= '0;
      atoi_q        <= AT_SPACE;
      neg_q         <= 1'b0;
    end else if (pop) begin
      if (pop_entry_i.last) begin
        phase_q       <= PH_SCHEME;
        hash_q        <= FNV_BASIS;
        recent_q      <= '0;
        pos_q         <= '0;
        host_begin_q  <= '0;
        host_end_q    <= '0;
        acc_q         <= '0;
        path_begin_q  <= '0;
        path_found_q  <= 1'b0;
        colon_q       <= 1'b0;
        slash_q       <= 1'b0;
        first_slash_q <= '0;
        atoi_q        <= AT_SPACE;
        neg_q         <= 1'b0;
      end else begin
        phase_q       <= phase_d;
        hash_q        <= hash_d;
        recent_q      <= recent_d;
        pos_q         <= pos_d;
        host_begin_q  <= host_begin_d;
        host_end_q    <= host_end_d;
        acc_q         <= acc_d;
        path_begin_q  <= path_begin_d;
        path_found_q  <= path_found_d;
        colon_q       <= colon_d;
        slash_q       <= slash_d;
        first_slash_q <= first_slash_d;
        atoi_q        <= atoi_d;
        neg_q         <= neg_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop && pop_entry_i.last) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Error results carry only the status.
  always_ff @(posedge clk_i) begin
    if (pop && pop_entry_i.last) begin
      status_q <= res_status;
      if (res_status == ST_OK) begin
        kind_q         <= res_kind;
        host_start_q   <= 8'(host_begin_d);
        host_length_q  <= 8'(res_host_end) - 8'(host_begin_d);
        port_q         <= res_port;
        known_q        <= res_known;
        path_present_q <= res_path_found;
        path_start_q   <= res_path_found ? 8'(res_path_begin) : 8'd0;
      end else begin
        kind_q         <= KIND_OTHER;
        host_start_q   <= '0;
        host_length_q  <= '0;
        port_q         <= '0;
        known_q        <= 1'b0;
        path_present_q <= 1'b0;
        path_start_q   <= '0;
      end
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.status       = status_q;
  assign result_o.scheme_kind  = kind_q;
  assign result_o.host_start   = host_start_q;
  assign result_o.host_length  = host_length_q;
  assign result_o.port         = port_q;
  assign result_o.port_known   = known_q;
  assign result_o.path_present = path_present_q;
  assign result_o.path_start   = path_start_q;

endmodule
